/* hw/rtl/mgsa_pkg.sv */
// mgsa_pkg: shared types and constants for the max-gap slot allocator
// used by mgsa_ctrl, mgsa_datapath and max_gap_slot_allocator_core
package mgsa_pkg;

   // fixed field widths
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 7;

   // default row size and slot_count reset value
   localparam int MGSA_MAX_SLOTS_DEFAULT = 64;
   localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 7'd64;

   // request opcodes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic load;
      logic scan_step;
      logic finish;
      logic rel_read;
      logic rel_check;
      logic commit;
   } mgsa_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic scan_done;
      logic out_free;
   } mgsa_stat_type;

endpackage

/* hw/rtl/mgsa_ram.sv */
// mgsa_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module mgsa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mgsa_ctrl.sv */
// mgsa_ctrl: sequencing state machine for the slot allocator
// depends on mgsa_pkg; drives mgsa_datapath through mgsa_cmd_type
module mgsa_ctrl
   import mgsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_op,
   input  mgsa_stat_type stat,
   output mgsa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FIN,
      S_REL_RD,
      S_REL_CHK,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_ALLOC) ? S_SCAN : S_REL_RD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               cmd.scan_step = 1'b0;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_REL_RD: begin
            cmd.rel_read = 1'b1;
            state_in     = S_REL_CHK;
         end
         S_REL_CHK: begin
            cmd.rel_check = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/mgsa_datapath.sv */
// mgsa_datapath: occupancy ram, gap scan, release check and response register
// depends on mgsa_pkg and mgsa_ram; commanded by mgsa_ctrl
module mgsa_datapath
   import mgsa_pkg::*;
#(
   parameter int MAX_SLOTS = MGSA_MAX_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  mgsa_cmd_type        cmd,
   output mgsa_stat_type       stat,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_granted_slot,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // control registers
   logic [CFG_W-1:0]    slot_count_ff, slot_count_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                issued_ff, issued_in;
   logic                have_prev_ff, have_prev_in;
   logic                wr_pend_ff, wr_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [IDX_W-1:0]    issued_idx_ff, issued_idx_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic [IDX_W-1:0]    best_d_ff, best_d_in;
   logic [IDX_W-1:0]    best_seat_ff, best_seat_in;
   logic [IDX_W-1:0]    wr_addr_ff, wr_addr_in;
   logic                wr_data_ff, wr_data_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // ram ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic             ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic             ram_rdata;

   // helpers
   logic [WIDE_W-1:0] sc_ext;
   logic [WIDE_W-1:0] idx_ext;
   logic [CNT_W-1:0]  count;
   logic              idx_in_range;
   logic [IDX_W-1:0]  idx_addr;
   logic              addr_lt_count;
   logic [IDX_W-1:0]  gap_half;
   logic [IDX_W-1:0]  end_gap;
   logic [IDX_W-1:0]  last_seat;
   logic [IDX_W-1:0]  fin_d;
   logic [IDX_W-1:0]  fin_seat;

   // effective slot count, clamped to 1..MAX_SLOTS
   assign sc_ext = WIDE_W'(slot_count_ff);
   always_comb begin
      if (slot_count_ff == '0) begin
         count = CNT_W'(1);
      end else if (sc_ext > WIDE_W'(MAX_SLOTS)) begin
         count = CNT_W'(MAX_SLOTS);
      end else begin
         count = CNT_W'(sc_ext);
      end
   end

   assign idx_ext       = WIDE_W'(idx_ff);
   assign idx_in_range  = idx_ext < WIDE_W'(count);
   assign idx_addr      = idx_ext[IDX_W-1:0];
   assign addr_lt_count = addr_ff < count;

   // gap arithmetic
   assign gap_half  = (issued_idx_ff - prev_ff) >> 1;
   assign end_gap   = IDX_W'(count - CNT_W'(1) - CNT_W'(prev_ff));
   assign last_seat = IDX_W'(count - CNT_W'(1));

   // right-end candidate folded into the best gap
   always_comb begin
      if (end_gap > best_d_ff) begin
         fin_d    = end_gap;
         fin_seat = last_seat;
      end else begin
         fin_d    = best_d_ff;
         fin_seat = best_seat_ff;
      end
   end

   // status to controller
   assign stat.clear_last = (addr_ff == CNT_W'(MAX_SLOTS - 1));
   assign stat.scan_done  = !addr_lt_count && !issued_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // ram access muxing
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff[IDX_W-1:0];
      ram_wdata = 1'b0;
      if (cmd.commit && wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = wr_data_ff;
      end else if (cmd.clear_step) begin
         ram_we = 1'b1;
      end
      ram_raddr = cmd.rel_read ? idx_addr : addr_ff[IDX_W-1:0];
   end

   // next-state logic
   always_comb begin
      slot_count_in = slot_count_ff;
      addr_in       = addr_ff;
      issued_in     = issued_ff;
      issued_idx_in = issued_idx_ff;
      have_prev_in  = have_prev_ff;
      prev_in       = prev_ff;
      best_d_in     = best_d_ff;
      best_seat_in  = best_seat_ff;
      idx_in        = idx_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;

      // configuration write
      if (csr_wr_en) begin
         slot_count_in = csr_wr_data;
      end

      // clearing pass after reset
      if (cmd.clear_step) begin
         addr_in = addr_ff + CNT_W'(1);
      end

      // start of a new request
      if (cmd.load) begin
         idx_in       = req_slot_index;
         addr_in      = '0;
         issued_in    = 1'b0;
         have_prev_in = 1'b0;
         prev_in      = '0;
         best_d_in    = '0;
         best_seat_in = '0;
         wr_pend_in   = 1'b0;
      end

      // issue one read per cycle during the scan
      if (cmd.scan_step) begin
         issued_in     = addr_lt_count;
         issued_idx_in = addr_ff[IDX_W-1:0];
         if (addr_lt_count) begin
            addr_in = addr_ff + CNT_W'(1);
         end
      end

      // evaluate the slot whose read data just came back
      if (issued_ff && ram_rdata) begin
         if (!have_prev_ff) begin
            if (issued_idx_ff > best_d_ff) begin
               best_d_in    = issued_idx_ff;
               best_seat_in = '0;
            end
         end else if (gap_half > best_d_ff) begin
            best_d_in    = gap_half;
            best_seat_in = prev_ff + gap_half;
         end
         have_prev_in = 1'b1;
         prev_in      = issued_idx_ff;
      end

      // allocation decision
      if (cmd.finish) begin
         if (!have_prev_ff) begin
            wr_pend_in    = 1'b1;
            wr_addr_in    = '0;
            wr_data_in    = 1'b1;
            res_slot_in   = '0;
            res_status_in = ST_OK;
         end else if (fin_d == '0) begin
            wr_pend_in    = 1'b0;
            res_slot_in   = '0;
            res_status_in = ST_FULL;
         end else begin
            wr_pend_in    = 1'b1;
            wr_addr_in    = fin_seat;
            wr_data_in    = 1'b1;
            res_slot_in   = SLOT_W'(fin_seat);
            res_status_in = ST_OK;
         end
      end

      // release check against the occupancy bit
      if (cmd.rel_check) begin
         res_slot_in = idx_ff;
         wr_addr_in  = idx_addr;
         wr_data_in  = 1'b0;
         if (idx_in_range && ram_rdata) begin
            wr_pend_in    = 1'b1;
            res_status_in = ST_OK;
         end else begin
            wr_pend_in    = 1'b0;
            res_status_in = ST_BAD_RELEASE;
         end
      end

      // response register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = res_slot_ff;
         rsp_status_in = res_status_ff;
         wr_pend_in    = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
         addr_ff       <= '0;
         issued_ff     <= 1'b0;
         have_prev_ff  <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         addr_ff       <= addr_in;
         issued_ff     <= issued_in;
         have_prev_ff  <= have_prev_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      issued_idx_ff <= issued_idx_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      best_d_ff     <= best_d_in;
      best_seat_ff  <= best_seat_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // occupancy map
   mgsa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* hw/rtl/max_gap_slot_allocator_core.sv */
// max_gap_slot_allocator_core: top level of the max-gap slot allocator
// depends on mgsa_pkg, mgsa_ctrl, mgsa_datapath and mgsa_ram
//
// Usage:
//   req channel (req_valid/req_ready, req_op, req_slot_index): op 0 allocates the
//   free slot farthest from any taken slot (lowest index on ties), op 1 releases
//   req_slot_index. rsp channel (rsp_valid/rsp_ready, rsp_granted_slot,
//   rsp_status) returns exactly one response per request transfer.
//   csr_wr_en/csr_wr_data write slot_count (clamped to 1..MAX_SLOTS); write only
//   while no request is in flight.
// Throughput:
//   one request at a time. An allocate scans the occupancy ram one slot per
//   cycle through its registered read port, then decides the grant; a release reads
//   the slot's occupancy bit and checks it. The next request is taken once the
//   response has been loaded into the output register.
// Reset:
//   synchronous; after reset a clearing pass writes every ram entry, during
//   which req_ready stays low. slot_count resets to 64.
// Stalls:
//   a held response sits in the output register; the next request is still
//   taken, and its result waits until the previous response is transferred.
module max_gap_slot_allocator_core
   import mgsa_pkg::*;
#(
   parameter int MAX_SLOTS = MGSA_MAX_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [SLOT_W-1:0]   req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_granted_slot,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data
);

   mgsa_cmd_type  cmd;
   mgsa_stat_type stat;

   // sequencer
   mgsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd)
   );

   // map, scan and response register
   mgsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_slot_index   (req_slot_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_status       (rsp_status)
   );

endmodule

/* verif/max_gap_slot_allocator_core_test.sv */
`timescale 1ns / 1ps
// max_gap_slot_allocator_core_test: self-checking testbench for the max-gap slot allocator
// depends on mgsa_pkg and max_gap_slot_allocator_core; checks every response in order
module max_gap_slot_allocator_core_test;
   import mgsa_pkg::*;

   localparam int MAX_SLOTS       = MGSA_MAX_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT     = 1500000;
   localparam int HOLD_CYCLES     = 400;
   localparam int TAIL_CYCLES     = MAX_SLOTS + 16;
   localparam int MAX_GAP         = 40;
   localparam int PHASES_PER_MODE = 6;
   localparam int ITEMS_PER_PHASE = 103;

   typedef struct packed {
      logic [SLOT_W-1:0]   granted_slot;
      logic [STATUS_W-1:0] status;
   } grant_type;

   // block ports
   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_op         = OP_ALLOC;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [SLOT_W-1:0]   rsp_granted_slot;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_wr_en      = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data    = '0;

   // predicted row state and pending grants
   logic [MAX_SLOTS-1:0] occ_map      = '0;
   logic [CFG_W-1:0]     row_size_reg = SLOT_COUNT_RESET;
   grant_type            grant_q[$];

   // run bookkeeping
   int fail_count        = 0;
   int cycle_count       = 0;
   int n_requests        = 0;
   int n_alloc           = 0;
   int n_full            = 0;
   int n_bad_release     = 0;
   int n_row_writes      = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_ticket       = 0;

   max_gap_slot_allocator_core #(
      .MAX_SLOTS(MAX_SLOTS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // row size as the block sees it, clamped to 1..MAX_SLOTS
   function automatic int unsigned visible_count();
      int unsigned count;
      count = row_size_reg;
      if (count < 1) count = 1;
      if (count > MAX_SLOTS) count = MAX_SLOTS;
      return count;
   endfunction

   // work out the grant for one accepted request and queue it
   function automatic void predict_grant(input logic op, input logic [SLOT_W-1:0] idx);
      int unsigned count;
      int unsigned prev;
      int unsigned best_d;
      int unsigned best_slot;
      int unsigned gap_d;
      bit          have_prev;
      grant_type   g;
      count     = visible_count();
      prev      = 0;
      best_d    = 0;
      best_slot = 0;
      have_prev = 1'b0;
      n_requests++;
      if (op == OP_RELEASE) begin
         g.granted_slot = idx;
         if (idx < count && occ_map[idx]) begin
            occ_map[idx] = 1'b0;
            g.status     = ST_OK;
         end else begin
            g.status = ST_BAD_RELEASE;
            n_bad_release++;
         end
      end else begin
         n_alloc++;
         // walk taken slots: left end, then midpoints of interior gaps
         for (int unsigned i = 0; i < count; i++) begin
            if (occ_map[i]) begin
               if (!have_prev) begin
                  if (i > best_d) begin
                     best_d    = i;
                     best_slot = 0;
                  end
               end else begin
                  gap_d = (i - prev) / 2;
                  if (gap_d > best_d) begin
                     best_d    = gap_d;
                     best_slot = prev + gap_d;
                  end
               end
               have_prev = 1'b1;
               prev      = i;
            end
         end
         if (!have_prev) begin
            // empty row always gets slot 0
            occ_map[0]     = 1'b1;
            g.granted_slot = '0;
            g.status       = ST_OK;
         end else begin
            // right end candidate
            if (count - 1 - prev > best_d) begin
               best_d    = count - 1 - prev;
               best_slot = count - 1;
            end
            if (best_d == 0) begin
               g.granted_slot = '0;
               g.status       = ST_FULL;
               n_full++;
            end else begin
               occ_map[best_slot] = 1'b1;
               g.granted_slot     = SLOT_W'(best_slot);
               g.status           = ST_OK;
            end
         end
      end
      grant_q.push_back(g);
   endfunction

   // a taken slot inside the visible row, or any slot when none is taken
   function automatic logic [SLOT_W-1:0] pick_taken_slot();
      int unsigned taken[$];
      for (int unsigned i = 0; i < visible_count(); i++) begin
         if (occ_map[i]) taken.push_back(i);
      end
      if (taken.size() == 0) return SLOT_W'($urandom_range(MAX_SLOTS - 1));
      return SLOT_W'(taken[$urandom_range(taken.size() - 1)]);
   endfunction

   // offer one request; returns at the edge of its transfer with valid still high
   task automatic send_request(input logic op, input logic [SLOT_W-1:0] idx);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_slot_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_grant(op, idx);
   endtask

   // stop offering and wait until every grant is back and the block is ready
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grant_q.size() != 0 || !req_ready) @(posedge clock);
   endtask

   // write slot_count while the block is idle
   task automatic write_row_size(input logic [CFG_W-1:0] row_size);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= row_size;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      row_size_reg  = row_size;
      n_row_writes++;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // response checker: each transfer against the oldest pending grant
   initial begin
      grant_type g;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               $error("unexpected response: granted_slot %0d status %0d",
                      rsp_granted_slot, rsp_status);
               fail_count++;
            end else begin
               g = grant_q.pop_front();
               if (rsp_granted_slot !== g.granted_slot) begin
                  $error("granted_slot: expected %0d, actual %0d",
                         g.granted_slot, rsp_granted_slot);
                  fail_count++;
               end
               if (rsp_status !== g.status) begin
                  $error("status: expected %0d, actual %0d", g.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // empty row, both ends, interior midpoint, double release
   task automatic test_row_ends();
      send_request(OP_ALLOC, 6'h3f);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_RELEASE, 6'd31);
      send_request(OP_RELEASE, 6'd31);
      send_request(OP_RELEASE, 6'd0);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_RELEASE, 6'h3f);
   endtask

   // tiny rows, zero and oversized counts, slots hidden above the count
   task automatic test_clamped_row_sizes();
      write_row_size(7'd1);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_RELEASE, 6'd0);
      send_request(OP_RELEASE, 6'd15);
      write_row_size(7'd0);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_ALLOC, 6'h2a);
      write_row_size(7'h7f);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_RELEASE, 6'h3f);
      write_row_size(7'd2);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_ALLOC, 6'h00);
      send_request(OP_RELEASE, 6'd2);
   endtask

   // long receiver hold-off while requests keep coming, then a full pause
   task automatic test_backpressure();
      write_row_size(7'd16);
      hold_ticket <= hold_ticket + 1;
      repeat (10) send_request(($urandom_range(99) < 70) ? OP_ALLOC : OP_RELEASE,
                               pick_taken_slot());
      wait_drained();
   endtask

   // one row size, then mostly well-formed traffic with some stray releases
   task automatic run_random_phase(input logic [CFG_W-1:0] row_size, input int n_items);
      logic              op;
      logic [SLOT_W-1:0] idx;
      write_row_size(row_size);
      repeat (n_items) begin
         idx = SLOT_W'($urandom_range(MAX_SLOTS - 1));
         if ($urandom_range(99) < 55) begin
            op = OP_ALLOC;
         end else begin
            op = OP_RELEASE;
            if ($urandom_range(99) < 80) idx = pick_taken_slot();
         end
         send_request(op, idx);
      end
   endtask

   // random traffic under one idling mix
   task automatic test_random_traffic(input int tx_idle_pct, input int rx_idle_pct);
      logic [CFG_W-1:0] row_size;
      sender_idle_pct    = tx_idle_pct;
      receiver_idle_pct <= rx_idle_pct;
      for (int p = 0; p < PHASES_PER_MODE; p++) begin
         case (p)
            0: begin
               row_size = CFG_W'(MAX_SLOTS);
            end
            1: begin
               row_size = 7'd1;
            end
            default: begin
               // small rows keep allocate scans short
               if ($urandom_range(99) < 70) row_size = CFG_W'($urandom_range(16, 1));
               else row_size = CFG_W'($urandom_range(127, 17));
            end
         endcase
         run_random_phase(row_size, ITEMS_PER_PHASE);
      end
   endtask

   // test sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_row_ends();
      test_clamped_row_sizes();
      test_backpressure();
      test_random_traffic(22, 47);
      test_random_traffic(47, 22);
      test_random_traffic(0, 0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d requests: %0d allocates (%0d into a full row), %0d bad releases",
               n_requests, n_alloc, n_full, n_bad_release);
      $display("%0d slot_count writes, %0d cycles, %0d mismatches",
               n_row_writes, cycle_count, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
